// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the correspondence block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication assertion, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication assertion
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lfc_pkg.sv =====
`timescale 1ns / 1ps
package lfc_pkg;
  localparam int MAP_POINTS = 4096;
  localparam int IDX_W = $clog2(MAP_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int COORD_W = 21;
  localparam int RING_W = 6;
  localparam int DIST_W = 44;
  localparam int CFG_W = 44;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_IDX_W = 12;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_LOAD_EDGE = 3'd1;
  localparam logic [2:0] REQ_LOAD_PLANE = 3'd2;
  localparam logic [2:0] REQ_Q_EDGE = 3'd3;
  localparam logic [2:0] REQ_Q_PLANE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_FOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd1;

  typedef struct packed {
    logic [2:0] req_type;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [RING_W-1:0] scan_ring;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [OUT_IDX_W-1:0] closest_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic [OUT_IDX_W-1:0] third_index;
  } res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RING_W-1:0] ring;
  } point_t;

  // memory port bundle from sequencer to map store
  typedef struct packed {
    logic we;
    logic sel_plane;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    point_t wdata;
  } mem_req_t;
endpackage

// ===== hw/rtl/lfc_stream_if.sv =====
`timescale 1ns / 1ps
interface lfc_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lfc_map_store.sv =====
`timescale 1ns / 1ps
module lfc_map_store (
  input  logic             clk,
  input  lfc_pkg::mem_req_t mreq,
  output lfc_pkg::point_t  rdata
);
  import lfc_pkg::*;
  point_t edge_mem [MAP_POINTS];
  point_t plane_mem [MAP_POINTS];
  point_t edge_q, plane_q;
  logic sel_r;

  always_ff @(posedge clk) begin
    if (mreq.we && !mreq.sel_plane) edge_mem[mreq.waddr] <= mreq.wdata;
    if (mreq.we && mreq.sel_plane) plane_mem[mreq.waddr] <= mreq.wdata;
    edge_q <= edge_mem[mreq.raddr];
    plane_q <= plane_mem[mreq.raddr];
    sel_r <= mreq.sel_plane;
  end

  assign rdata = sel_r ? plane_q : edge_q;
endmodule

// ===== hw/rtl/lfc_dist.sv =====
`timescale 1ns / 1ps
// squared distance, two stages: multiply, then sum
module lfc_dist (
  input  logic clk,
  input  lfc_pkg::point_t p,
  input  logic signed [lfc_pkg::COORD_W-1:0] qx,
  input  logic signed [lfc_pkg::COORD_W-1:0] qy,
  input  logic signed [lfc_pkg::COORD_W-1:0] qz,
  output logic [lfc_pkg::DIST_W-1:0] sq_dist
);
  import lfc_pkg::*;
  logic signed [COORD_W:0] dx, dy, dz;
  logic signed [2*COORD_W+1:0] px, py, pz;
  logic [2*COORD_W+1:0] sx_r, sy_r, sz_r;
  logic [2*COORD_W+3:0] sum;

  assign dx = {p.x[COORD_W-1], p.x} - {qx[COORD_W-1], qx};
  assign dy = {p.y[COORD_W-1], p.y} - {qy[COORD_W-1], qy};
  assign dz = {p.z[COORD_W-1], p.z} - {qz[COORD_W-1], qz};

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign sum = {2'b0, sx_r} + {2'b0, sy_r} + {2'b0, sz_r};

  always_ff @(posedge clk) begin
    sx_r <= $unsigned(px);
    sy_r <= $unsigned(py);
    sz_r <= $unsigned(pz);
    sq_dist <= sum[DIST_W-1:0];
  end
endmodule

// ===== hw/rtl/lfc_search.sv =====
`timescale 1ns / 1ps
module lfc_search (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  output logic req_ready,
  input  lfc_pkg::req_t req,
  output logic res_valid,
  input  logic res_ready,
  output lfc_pkg::res_t res,
  input  logic [lfc_pkg::DIST_W-1:0] thresh,
  input  logic [lfc_pkg::RING_W-1:0] window,
  output lfc_pkg::mem_req_t mreq,
  input  lfc_pkg::point_t rdata
);
  import lfc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEAR = 3'd1;
  localparam logic [2:0] S_CRD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] ecnt_r, pcnt_r;
  req_t q_r;
  logic plane_r, dir_r;
  logic [CNT_W-1:0] n_r;
  // issue index and three-stage tag pipe (read, mul, sum)
  logic [CNT_W-1:0] ia_r;
  logic [2:0] v_r;
  logic [IDX_W-1:0] t0_r, t1_r, t2_r;
  logic [RING_W-1:0] rg1_r, rg2_r;
  logic stop_r;
  logic have_r, h2_r, h3_r;
  logic [DIST_W-1:0] best_r, d2_r, d3_r;
  logic [IDX_W-1:0] c_r, i2_r, i3_r;
  logic [RING_W-1:0] cr_r;
  logic [DIST_W-1:0] sq_dist;
  logic res_v_r;
  res_t res_r;

  lfc_dist u_dist (.clk, .p(rdata), .qx(q_r.pos_x), .qy(q_r.pos_y), .qz(q_r.pos_z),
    .sq_dist);

  assign req_ready = (state_r == S_IDLE) && !res_v_r;
  assign res_valid = res_v_r;
  assign res = res_r;

  logic acc;
  assign acc = req_valid && req_ready;

  // ring checks on the entry leaving the read stage
  logic [RING_W-1:0] rr;
  logic [RING_W-1:0] rdiff;
  logic same_ring, out_win;
  assign rr = rdata.ring;
  assign rdiff = (rr > cr_r) ? rr - cr_r : cr_r - rr;
  assign same_ring = rr == cr_r;
  assign out_win = rdiff > window;

  // a scan stop seen at read stage kills further issues
  logic out_win_kill;
  assign out_win_kill = (state_r == S_SCAN) && !(!plane_r && same_ring) && out_win;

  logic issue, in_range;
  logic [CNT_W-1:0] ia_nxt;
  always_comb begin
    in_range = dir_r ? (ia_r != '1) : (ia_r < n_r);
    issue = 1'b0;
    if (state_r == S_NEAR) issue = ia_r < n_r;
    else if (state_r == S_CRD) issue = !v_r[0];
    else if (state_r == S_SCAN) issue = in_range && !stop_r && !(v_r[0] && out_win_kill);
  end

  always_comb begin
    mreq = '0;
    mreq.sel_plane = acc ? (req.req_type == REQ_LOAD_PLANE) : plane_r;
    mreq.raddr = ia_r[IDX_W-1:0];
    mreq.waddr = (req.req_type == REQ_LOAD_PLANE) ? pcnt_r[IDX_W-1:0] : ecnt_r[IDX_W-1:0];
    mreq.wdata = '{x: req.pos_x, y: req.pos_y, z: req.pos_z, ring: req.scan_ring};
    if (acc && req.req_type == REQ_LOAD_EDGE) mreq.we = ecnt_r < CNT_W'(MAP_POINTS);
    if (acc && req.req_type == REQ_LOAD_PLANE) mreq.we = pcnt_r < CNT_W'(MAP_POINTS);
  end

  logic pipe_empty;
  assign pipe_empty = (v_r == 3'b0) && !issue;
  assign ia_nxt = dir_r ? ia_r - 1'b1 : ia_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ecnt_r <= '0;
      pcnt_r <= '0;
      v_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      if (res_v_r && res_ready) res_v_r <= 1'b0;
      // the closest-ring read never enters the distance stages
      v_r <= {v_r[1], v_r[0] && !(state_r == S_CRD || (state_r == S_SCAN &&
               (stop_r || out_win_kill || (!plane_r && same_ring)))), issue};
      t0_r <= ia_r[IDX_W-1:0];
      t1_r <= t0_r;
      t2_r <= t1_r;
      rg1_r <= rr;
      rg2_r <= rg1_r;
      if (issue) ia_r <= ia_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            q_r <= req;
            unique case (req.req_type)
              REQ_START: begin
                ecnt_r <= '0;
                pcnt_r <= '0;
                res_r <= '{status: ST_OK, default: '0};
                res_v_r <= 1'b1;
              end
              REQ_LOAD_EDGE: begin
                if (ecnt_r < CNT_W'(MAP_POINTS)) begin
                  ecnt_r <= ecnt_r + 1'b1;
                  res_r <= '{status: ST_OK, default: '0};
                end else res_r <= '{status: ST_FULL, default: '0};
                res_v_r <= 1'b1;
              end
              REQ_LOAD_PLANE: begin
                if (pcnt_r < CNT_W'(MAP_POINTS)) begin
                  pcnt_r <= pcnt_r + 1'b1;
                  res_r <= '{status: ST_OK, default: '0};
                end else res_r <= '{status: ST_FULL, default: '0};
                res_v_r <= 1'b1;
              end
              REQ_Q_EDGE, REQ_Q_PLANE: begin
                plane_r <= req.req_type == REQ_Q_PLANE;
                n_r <= (req.req_type == REQ_Q_PLANE) ? pcnt_r : ecnt_r;
                ia_r <= '0;
                dir_r <= 1'b0;
                have_r <= 1'b0;
                state_r <= S_NEAR;
              end
              default: begin
                res_r <= '{status: ST_OK, default: '0};
                res_v_r <= 1'b1;
              end
            endcase
          end
        end
        S_NEAR: begin
          if (v_r[2] && (!have_r || sq_dist < best_r)) begin
            best_r <= sq_dist;
            c_r <= t2_r;
            have_r <= 1'b1;
          end
          if (pipe_empty) begin
            if (have_r && best_r < thresh) begin
              ia_r <= {1'b0, c_r};
              state_r <= S_CRD;
            end else begin
              res_r <= '{status: ST_NONE, default: '0};
              res_v_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        S_CRD: begin
          // read closest ring, then start forward scan
          if (v_r[0]) begin
            cr_r <= rr;
            ia_r <= {1'b0, c_r} + 1'b1;
            dir_r <= 1'b0;
            stop_r <= 1'b0;
            h2_r <= 1'b0;
            h3_r <= 1'b0;
            d2_r <= thresh;
            d3_r <= thresh;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (v_r[0] && out_win_kill) stop_r <= 1'b1;
          if (v_r[2]) begin
            if (!plane_r || (dir_r ? rg2_r >= cr_r : rg2_r <= cr_r)) begin
              if (sq_dist < d2_r) begin d2_r <= sq_dist; i2_r <= t2_r; h2_r <= 1'b1; end
            end else if (sq_dist < d3_r) begin
              d3_r <= sq_dist; i3_r <= t2_r; h3_r <= 1'b1;
            end
          end
          if (pipe_empty) begin
            if (!dir_r) begin
              dir_r <= 1'b1;
              stop_r <= 1'b0;
              ia_r <= {1'b0, c_r} - 1'b1;
            end else state_r <= S_DONE;
          end
        end
        S_DONE: begin
          res_r <= '{status: (h2_r && (!plane_r || h3_r)) ? ST_FOUND : ST_NONE,
                     closest_index: OUT_IDX_W'(c_r),
                     second_index: h2_r ? OUT_IDX_W'(i2_r) : '0,
                     third_index: (plane_r && h3_r) ? OUT_IDX_W'(i3_r) : '0};
          res_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/lidar_feature_correspondence.sv =====
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | req_type, pos_x, pos_y, pos_z, scan_ring
// out     | out | status, closest_index, second_index, third_index
// Start and load requests answer in the cycle after they are taken; a query runs the
// nearest-point pass, reads the closest ring, then per scan direction reads each
// neighbour and drains the pipe, and then forms the result; an empty map or a
// nearest point beyond the limit answers after the nearest-point pass.
// These steps run one after another on the single read port of the map memory.
// One request at a time; a new request is taken once the result is taken.
// Synchronous active-low reset clears counts and control; maps need no clearing.
module lidar_feature_correspondence (
  input  logic clk,
  input  logic rst_n,
  lfc_stream_if.sink   in_ch,
  lfc_stream_if.source out_ch,
  input  logic cfg_we,
  input  logic [lfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfc_pkg::CFG_W-1:0] cfg_data
);
  import lfc_pkg::*;
  logic [DIST_W-1:0] thresh_r;
  logic [RING_W-1:0] window_r;
  mem_req_t mreq;
  point_t rdata;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= DIST_W'(25000000);
      window_r <= RING_W'(3);
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESH) thresh_r <= cfg_data[DIST_W-1:0];
      if (cfg_index == CFG_WINDOW) window_r <= cfg_data[RING_W-1:0];
    end
  end

  lfc_map_store u_store (.clk, .mreq, .rdata);

  lfc_search u_search (
    .clk, .rst_n,
    .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req(req_t'(in_ch.data)),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res,
    .thresh(thresh_r), .window(window_r), .mreq, .rdata);

  assign out_ch.data = res;
endmodule

// ===== hw/rtl/lfc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lfc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [37:0] out_data
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `ASSERT_IMPL(a_one_at_a_time, clk, rst_n, out_valid, !in_ready, "request taken while result waits")
  `ASSERT_NEXT(a_busy_after, clk, rst_n, in_valid && in_ready, !in_ready, "request taken twice")
endmodule

bind lidar_feature_correspondence lfc_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

// ===== tb/tb_lidar_feature_correspondence.sv =====
`timescale 1ns / 1ps
module tb_lidar_feature_correspondence;
  import lfc_pkg::*;

  localparam int IN_W = $bits(req_t);
  localparam int OUT_W = $bits(res_t);
  localparam longint CYCLE_LIMIT = 4000000;
  // request codes with no function
  localparam logic [2:0] REQ_SPARE_A = 3'd5;
  localparam logic [2:0] REQ_SPARE_B = 3'd6;
  localparam logic [2:0] REQ_SPARE_C = 3'd7;

  // predicts each result from a private copy of both feature maps
  class corr_scoreboard;
    point_t emap[MAP_POINTS];
    point_t pmap[MAP_POINTS];
    int ecnt, pcnt;
    logic [DIST_W-1:0] thr;
    logic [RING_W-1:0] win;
    res_t expq[$];
    int errors;

    function new();
      ecnt = 0;
      pcnt = 0;
      thr = 44'd25000000;
      win = 6'd3;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_THRESH) thr = val[DIST_W-1:0];
      else if (idx == CFG_WINDOW) win = val[RING_W-1:0];
    endfunction

    function longint dsq(point_t p, req_t q);
      longint dx, dy, dz;
      dx = longint'(p.x) - longint'(q.pos_x);
      dy = longint'(p.y) - longint'(q.pos_y);
      dz = longint'(p.z) - longint'(q.pos_z);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function point_t pt(bit plane, int j);
      return plane ? pmap[j] : emap[j];
    endfunction

    function res_t search(bit plane, req_t q);
      res_t r;
      point_t p;
      int n, c, j, cr, rr, diff;
      longint best, d, d2, d3;
      bit h2, h3, sec;
      r = '0;
      r.status = ST_NONE;
      n = plane ? pcnt : ecnt;
      if (n == 0) return r;
      c = 0;
      best = dsq(pt(plane, 0), q);
      for (int i = 1; i < n; i++) begin
        d = dsq(pt(plane, i), q);
        if (d < best) begin
          best = d;
          c = i;
        end
      end
      if (!(best < longint'(thr))) return r;
      p = pt(plane, c);
      cr = p.ring;
      d2 = longint'(thr);
      d3 = longint'(thr);
      h2 = 0;
      h3 = 0;
      r.closest_index = OUT_IDX_W'(c);
      for (int dir = 0; dir < 2; dir++) begin
        j = c;
        forever begin
          if (dir == 0) begin
            if (j + 1 >= n) break;
            j++;
          end else begin
            if (j == 0) break;
            j--;
          end
          p = pt(plane, j);
          rr = p.ring;
          if (!plane && rr == cr) continue;
          diff = (rr > cr) ? rr - cr : cr - rr;
          if (diff > int'(win)) break;
          d = dsq(p, q);
          sec = !plane || ((dir == 0) ? (rr <= cr) : (rr >= cr));
          if (sec) begin
            if (d < d2) begin
              d2 = d;
              r.second_index = OUT_IDX_W'(j);
              h2 = 1;
            end
          end else if (d < d3) begin
            d3 = d;
            r.third_index = OUT_IDX_W'(j);
            h3 = 1;
          end
        end
      end
      if (h2 && (!plane || h3)) r.status = ST_FOUND;
      return r;
    endfunction

    function void note(req_t q);
      res_t r;
      r = '0;
      r.status = ST_OK;
      case (q.req_type)
        REQ_START: begin
          ecnt = 0;
          pcnt = 0;
        end
        REQ_LOAD_EDGE: begin
          if (ecnt >= MAP_POINTS) r.status = ST_FULL;
          else begin
            emap[ecnt] = {q.pos_x, q.pos_y, q.pos_z, q.scan_ring};
            ecnt++;
          end
        end
        REQ_LOAD_PLANE: begin
          if (pcnt >= MAP_POINTS) r.status = ST_FULL;
          else begin
            pmap[pcnt] = {q.pos_x, q.pos_y, q.pos_z, q.scan_ring};
            pcnt++;
          end
        end
        REQ_Q_EDGE: r = search(0, q);
        REQ_Q_PLANE: r = search(1, q);
        default: ;
      endcase
      expq.insert(expq.size(), r);
    endfunction

    function void check(res_t a);
      res_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.closest_index !== e.closest_index) begin
        $display("%0t: closest_index exp %0d got %0d", $time, e.closest_index,
                 a.closest_index);
        errors++;
      end
      if (a.second_index !== e.second_index) begin
        $display("%0t: second_index exp %0d got %0d", $time, e.second_index,
                 a.second_index);
        errors++;
      end
      if (a.third_index !== e.third_index) begin
        $display("%0t: third_index exp %0d got %0d", $time, e.third_index,
                 a.third_index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lfc_stream_if #(.W(IN_W)) in_ch ();
  lfc_stream_if #(.W(OUT_W)) out_ch ();

  lidar_feature_correspondence uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  corr_scoreboard sb = new();
  bit quiet = 0;
  bit hold_go = 0;
  bit hold_used = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  int rx_gap = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(res_t'(out_ch.data));
    if (hold_go && !hold_used) begin
      hold_used <= 1;
      hold_cycles <= 400;
      out_ch.ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ch.ready <= 0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      rx_gap <= $urandom_range(1, 13) - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
    end
  end

  function req_t mk(logic [2:0] t, int x, int y, int z, int ring);
    req_t r;
    r.req_type = t;
    r.pos_x = COORD_W'(x);
    r.pos_y = COORD_W'(y);
    r.pos_z = COORD_W'(z);
    r.scan_ring = RING_W'(ring);
    return r;
  endfunction

  task send(req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(r);
  endtask

  task drain();
    in_ch.valid <= 0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  function int near(int c);
    return c + $urandom_range(0, 6000) - 3000;
  endfunction

  // well-formed frame: clustered points, then queries close to them
  task frame(int cx, int cy, int cz, int npts);
    int rb;
    rb = $urandom_range(4, 59);
    send(mk(REQ_START, 0, 0, 0, 0));
    repeat (npts) begin
      send(mk(REQ_LOAD_EDGE, near(cx), near(cy), near(cz), rb + $urandom_range(0, 8) - 4));
      send(mk(REQ_LOAD_PLANE, near(cx), near(cy), near(cz), rb + $urandom_range(0, 8) - 4));
    end
    repeat (3) begin
      send(mk(REQ_Q_EDGE, near(cx), near(cy), near(cz), $urandom_range(0, 63)));
      send(mk(REQ_Q_PLANE, near(cx), near(cy), near(cz), $urandom_range(0, 63)));
    end
  endtask

  task noise();
    send(mk(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom_range(0, 63)));
  endtask

  task random_part(int nitems);
    int sent;
    sent = 0;
    while (sent < nitems) begin
      if ($urandom_range(0, 9) < 7) begin
        frame($urandom_range(0, 2080000) - 1040000, $urandom_range(0, 2080000) - 1040000,
              $urandom_range(0, 2080000) - 1040000, 2);
        sent += 11;
      end else begin
        noise();
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty maps, extremes, ties, unused types
    send(mk(REQ_Q_EDGE, 0, 0, 0, 0));
    send(mk(REQ_Q_PLANE, 0, 0, 0, 0));
    send(mk(REQ_START, 0, 0, 0, 0));
    send(mk(REQ_LOAD_EDGE, -1048576, -1048576, -1048576, 0));
    send(mk(REQ_LOAD_EDGE, 1048575, 1048575, 1048575, 63));
    send(mk(REQ_Q_EDGE, -1048576, -1048576, -1048576, 0));
    send(mk(REQ_Q_EDGE, 0, 0, 0, 0));
    send(mk(REQ_START, 0, 0, 0, 0));
    send(mk(REQ_LOAD_EDGE, 100, 0, 0, 5));
    send(mk(REQ_LOAD_EDGE, -100, 0, 0, 6));
    send(mk(REQ_LOAD_EDGE, 100, 0, 0, 7));
    send(mk(REQ_LOAD_PLANE, 10, 0, 0, 5));
    send(mk(REQ_LOAD_PLANE, 20, 0, 0, 4));
    send(mk(REQ_LOAD_PLANE, 30, 0, 0, 6));
    send(mk(REQ_LOAD_PLANE, 40, 0, 0, 5));
    send(mk(REQ_Q_EDGE, 0, 0, 0, 0));
    send(mk(REQ_Q_PLANE, 25, 0, 0, 0));
    send(mk(REQ_Q_PLANE, 10, 0, 0, 0));
    send(mk(REQ_SPARE_A, 1, 2, 3, 4));
    send(mk(REQ_SPARE_B, -1, -2, -3, 63));
    send(mk(REQ_SPARE_C, 0, 0, 0, 0));
    send(mk(REQ_Q_PLANE, 1048575, 1048575, 1048575, 0));

    random_part(15);

    // long receiver hold-off while requests keep coming
    hold_go = 1;
    frame(0, 0, 0, 3);
    // sender pause until everything is back
    drain();

    write_reg(CFG_THRESH, '0);
    write_reg(CFG_WINDOW, '0);
    random_part(8);
    write_reg(CFG_THRESH, {CFG_W{1'b1}});
    write_reg(CFG_WINDOW, 44'd63);
    random_part(8);
    send(mk(REQ_Q_EDGE, -1048576, 1048575, -1048576, 0));

    write_reg(CFG_THRESH, 44'd4000000);
    write_reg(CFG_WINDOW, 44'd1);
    random_part(12);
    quiet = 1;
    random_part(8);

    in_ch.valid <= 0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lfc_pkg.sv
hw/rtl/lfc_stream_if.sv
hw/rtl/lfc_map_store.sv
hw/rtl/lfc_dist.sv
hw/rtl/lfc_search.sv
hw/rtl/lidar_feature_correspondence.sv
hw/rtl/lfc_checker.sv
tb/tb_lidar_feature_correspondence.sv
